[rtl/core/dild_pkg.sv]
package dild_pkg;

  localparam int OFFSET_BITS_DEFAULT = 32;
  localparam int MAX_LENGTH_DEFAULT  = 500;

  // Port widths fixed by the instruction format.
  localparam int UNIT_W   = 16;
  localparam int TOTAL_W  = 32;
  localparam int START_W  = 32;
  localparam int LENGTH_W = 9;

  // Payload lengths can reach 4 + (0xFFFF * 0xFFFFFFFF + 1) / 2.
  localparam int CALC_W = 49;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [UNIT_W-1:0] PACKED_SWITCH_ID = 16'h0100;
  localparam logic [UNIT_W-1:0] SPARSE_SWITCH_ID = 16'h0200;
  localparam logic [UNIT_W-1:0] FILL_ARRAY_ID    = 16'h0300;

  localparam logic [1:0] KIND_ORDINARY = 2'd0;
  localparam logic [1:0] KIND_PACKED   = 2'd1;
  localparam logic [1:0] KIND_SPARSE   = 2'd2;
  localparam logic [1:0] KIND_FILL     = 2'd3;

  // Undecoded units; unit[0] is the oldest. skip counts units still to drop.
  typedef struct packed {
    logic [QUEUE_DEPTH-1:0][UNIT_W-1:0] unit;
    logic [2:0]                         fill;
    logic [LENGTH_W-1:0]                skip;
  } queue_t;

  typedef struct packed {
    logic [7:0]          opcode;
    logic [LENGTH_W-1:0] length_units;
    logic [1:0]          kind;
    logic                clamped;
  } insn_t;

  localparam logic [2:0] SIZE_TABLE [256] = '{
    3'd1, 3'd1, 3'd2, 3'd3, 3'd1, 3'd2, 3'd3, 3'd1, 3'd2, 3'd3, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd1, 3'd1, 3'd1, 3'd2, 3'd3, 3'd2, 3'd2, 3'd3, 3'd5, 3'd2, 3'd2, 3'd3, 3'd2, 3'd1, 3'd1, 3'd2,
    3'd2, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd1, 3'd1, 3'd2, 3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd2,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3,
    3'd3, 3'd3, 3'd3, 3'd1, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd4, 3'd4, 3'd3, 3'd3, 3'd2, 3'd2
  };

  function automatic logic [2:0] op_units(input logic [7:0] op);
    return SIZE_TABLE[op];
  endfunction

endpackage

[rtl/core/dild_step.sv]
module dild_step #(
  parameter int OFFSET_BITS = dild_pkg::OFFSET_BITS_DEFAULT,
  parameter int MAX_LENGTH  = dild_pkg::MAX_LENGTH_DEFAULT
) (
  input  logic                              restart,
  input  logic [dild_pkg::UNIT_W-1:0]       code_unit,
  input  logic [dild_pkg::TOTAL_W-1:0]      total_units,
  input  logic [OFFSET_BITS-1:0]            offset,
  input  dild_pkg::queue_t                  cur,
  output dild_pkg::queue_t                  nxt,
  output logic [OFFSET_BITS-1:0]            offset_next,
  output logic                              res_valid,
  output logic [OFFSET_BITS-1:0]            res_start,
  output dild_pkg::insn_t                   res
);

  localparam int CW = dild_pkg::CALC_W;
  localparam int LW = dild_pkg::LENGTH_W;
  localparam int UW = dild_pkg::UNIT_W;

  dild_pkg::queue_t        qa;
  dild_pkg::queue_t        qb;
  logic [OFFSET_BITS-1:0]  off_a;
  logic [OFFSET_BITS-1:0]  off_b;
  logic [2:0]              pops;
  logic [UW-1:0]           front;
  logic [1:0]              kind;
  logic [2:0]              need;
  logic [2:0]              min_len;
  logic                    early;
  logic [47:0]             fill_prod;
  logic [CW-1:0]           fill_half;
  logic [CW-1:0]           calc_len;
  logic                    too_long;
  logic                    past_end;
  logic                    clamp;
  logic [LW-1:0]           final_len;

  // Restart empties the queue; then append the new unit.
  always_comb begin
    qa    = restart ? '0 : cur;
    off_a = restart ? '0 : offset;
    qa.unit[qa.fill[1:0]] = code_unit;
    qa.fill = qa.fill + 3'd1;
  end

  // Drop units left over from the previous instruction.
  always_comb begin
    pops   = (qa.skip < LW'(qa.fill)) ? qa.skip[2:0] : qa.fill;
    qb     = qa;
    qb.unit = qa.unit >> {pops, 4'b0000};
    qb.fill = qa.fill - pops;
    qb.skip = qa.skip - LW'(pops);
    off_b  = off_a + OFFSET_BITS'(pops);
  end

  assign front = qb.unit[0];

  always_comb begin
    unique case (front)
      dild_pkg::PACKED_SWITCH_ID: begin
        kind = dild_pkg::KIND_PACKED; need = 3'd2; min_len = 3'd4;
      end
      dild_pkg::SPARSE_SWITCH_ID: begin
        kind = dild_pkg::KIND_SPARSE; need = 3'd2; min_len = 3'd2;
      end
      dild_pkg::FILL_ARRAY_ID: begin
        kind = dild_pkg::KIND_FILL; need = 3'd4; min_len = 3'd4;
      end
      default: begin
        kind = dild_pkg::KIND_ORDINARY; need = 3'd1; min_len = 3'd1;
      end
    endcase
  end

  // A payload whose header cannot fit in the method is reported at once.
  assign early = (kind != dild_pkg::KIND_ORDINARY) &&
                 ((33'(off_b) + 33'(min_len)) > 33'(total_units));

  assign fill_prod = 48'(qb.unit[1]) * 48'({qb.unit[3], qb.unit[2]});
  assign fill_half = (CW'(fill_prod) + CW'(1)) >> 1;

  always_comb begin
    unique case (kind)
      dild_pkg::KIND_PACKED: calc_len = CW'({qb.unit[1], 1'b0}) + CW'(4);
      dild_pkg::KIND_SPARSE: calc_len = CW'({qb.unit[1], 2'b00}) + CW'(2);
      dild_pkg::KIND_FILL:   calc_len = fill_half + CW'(4);
      default:               calc_len = CW'(dild_pkg::op_units(front[7:0]));
    endcase
  end

  assign too_long  = calc_len > CW'(MAX_LENGTH);
  assign past_end  = (33'(off_b) + 33'(calc_len[LW-1:0])) > 33'(total_units);
  assign clamp     = early || too_long || (calc_len == '0) || past_end;
  assign final_len = clamp ? LW'(1) : calc_len[LW-1:0];

  assign res_valid = (qb.fill != 3'd0) && (early || (qb.fill >= need));
  assign res_start = off_b;
  assign res.opcode       = front[7:0];
  assign res.length_units = final_len;
  assign res.kind         = kind;
  assign res.clamped      = clamp;

  // Retire the front unit; the rest of the instruction drains on later beats.
  always_comb begin
    nxt         = qb;
    offset_next = off_b;
    if (res_valid) begin
      nxt.unit    = qb.unit >> UW;
      nxt.fill    = qb.fill - 3'd1;
      nxt.skip    = final_len - LW'(1);
      offset_next = off_b + OFFSET_BITS'(1);
    end
  end

endmodule

[rtl/core/dalvik_insn_length_decoder.sv]
// Dalvik instruction length decoder.
// Code units enter on the unit channel (unit_valid / unit_stall, payload
// code_unit and restart); restart marks the first unit of a method and
// zeroes the running offset. One beat per instruction leaves on the insn
// channel (insn_valid / insn_stall): start offset, opcode, length, kind
// and the clamped flag. Units inside an instruction produce no beat.
// total_units is written through cfg_we / cfg_wdata; the user writes it only
// while the block is idle; the block does not enforce this. Throughput is
// one unit per cycle unless the receiver stalls. Units are decoded from the
// input register into the result register; an instruction's beat comes from
// the unit that completes it: the first unit for ordinary opcodes, the last
// header unit for switch and fill-array payloads. Header units of a clamped
// payload are decoded one per later unit, so their beats trail the input by
// up to three units. The per-cycle figure is set by the decode recurrence
// (queue drain, kind decode, one 16x32 multiply, length compare) feeding the
// state registers. A stalled receiver holds the result register; one more
// unit is still taken into the input register, after which unit_stall rises.
// Reset clears the offset, pending payload state, total_units and both valids.
module dalvik_insn_length_decoder #(
  parameter int OFFSET_BITS = dild_pkg::OFFSET_BITS_DEFAULT,
  parameter int MAX_LENGTH  = dild_pkg::MAX_LENGTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [dild_pkg::TOTAL_W-1:0]      cfg_wdata,
  input  logic                              unit_valid,
  output logic                              unit_stall,
  input  logic [dild_pkg::UNIT_W-1:0]       code_unit,
  input  logic                              restart,
  output logic                              insn_valid,
  input  logic                              insn_stall,
  output logic [dild_pkg::START_W-1:0]      start_offset,
  output logic [7:0]                        opcode,
  output logic [dild_pkg::LENGTH_W-1:0]     length_units,
  output logic [1:0]                        kind,
  output logic                              clamped
);

  logic [dild_pkg::TOTAL_W-1:0]  total_units;
  logic [OFFSET_BITS-1:0]        offset;
  logic [OFFSET_BITS-1:0]        offset_next;
  dild_pkg::queue_t              queue;
  dild_pkg::queue_t              queue_next;

  // Input register.
  logic                          in_full;
  logic [dild_pkg::UNIT_W-1:0]   in_unit;
  logic                          in_restart;

  logic                          proc;
  logic                          take_in;
  logic                          take_out;
  logic                          res_valid;
  logic [OFFSET_BITS-1:0]        res_start;
  dild_pkg::insn_t               res;

  // Advance the input register into the decoder whenever the result register
  // is free or being drained this cycle.
  assign take_out   = insn_valid && !insn_stall;
  assign proc       = in_full && (!insn_valid || !insn_stall);
  assign unit_stall = in_full && !proc;
  assign take_in    = unit_valid && !unit_stall;

  dild_step #(
    .OFFSET_BITS (OFFSET_BITS),
    .MAX_LENGTH  (MAX_LENGTH)
  ) u_step (
    .restart     (in_restart),
    .code_unit   (in_unit),
    .total_units (total_units),
    .offset      (offset),
    .cur         (queue),
    .nxt         (queue_next),
    .offset_next (offset_next),
    .res_valid   (res_valid),
    .res_start   (res_start),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      total_units <= '0;
    end else if (cfg_we) begin
      total_units <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take_in) begin
      in_full <= 1'b1;
    end else if (proc) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      in_unit    <= code_unit;
      in_restart <= restart;
    end
  end

  // Decoder state: advance once per processed unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      queue  <= '0;
      offset <= '0;
    end else if (proc) begin
      queue  <= queue_next;
      offset <= offset_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      insn_valid <= 1'b0;
    end else begin
      insn_valid <= (proc && res_valid) || (insn_valid && !take_out);
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res_valid) begin
      start_offset <= dild_pkg::START_W'(res_start);
      opcode       <= res.opcode;
      length_units <= res.length_units;
      kind         <= res.kind;
      clamped      <= res.clamped;
    end
  end

  // The queue never rests full: a fourth unit always yields a result.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    queue.fill < 3'd4)
    else $error("unit queue holds more than three units at rest");

  a_length_range: assert property (@(posedge clk) disable iff (rst)
    insn_valid |-> (length_units != '0) &&
                   (length_units <= dild_pkg::LENGTH_W'(MAX_LENGTH)))
    else $error("instruction length out of range");

  a_clamp_one: assert property (@(posedge clk) disable iff (rst)
    (insn_valid && clamped) |-> (length_units == dild_pkg::LENGTH_W'(1)))
    else $error("clamped instruction with length other than one");

  a_restart_zero: assert property (@(posedge clk) disable iff (rst)
    (proc && in_restart && res_valid) |=> (start_offset == '0))
    else $error("instruction after restart does not start at offset zero");

endmodule

[verif/tb_dalvik_insn_length_decoder.sv]
`timescale 1ns / 100ps

module tb_dalvik_insn_length_decoder;

  // Hard stop for the whole run. The slowest correct run is well under a
  // millisecond, even with every gap and stall at its longest.
  localparam int RUN_LIMIT_NS = 5_000_000;
  // Code units per random phase. Six phases, each overshooting a little to
  // finish its last method, plus the directed tour give roughly 450 units.
  localparam int PHASE_UNITS = 60;
  localparam int NUM_PHASES  = 6;

  // Directed tour, bit 16 is the restart flag, bits 15:0 the code unit.
  // Part A runs with a 24-unit method body:
  //   nop at offset 0, opcode 0x12 with a full high byte, opcode 0xFF with its
  //   trailing unit, the 5-unit opcode 0x18 with extreme body units, a packed
  //   switch with no targets, then a fill-array payload whose header asks for
  //   an absurd length (clamped). A restart drops the buffered header, then a
  //   sparse switch with 0xFFFF keys is clamped, and its key-count unit is
  //   decoded on its own as opcode 0xFF.
  localparam logic [16:0] TOUR_A [20] = '{
    17'h1_0000, 17'h0_FF12, 17'h0_00FF, 17'h0_FFFF, 17'h0_0018,
    17'h0_AAAA, 17'h0_5555, 17'h0_0000, 17'h0_FFFF, 17'h0_0100,
    17'h0_0000, 17'h0_1234, 17'h0_8001, 17'h0_0300, 17'h0_FFFF,
    17'h0_FFFF, 17'h0_FFFF, 17'h1_0200, 17'h0_FFFF, 17'h0_0000
  };
  // Part B runs with a 2-unit body: each payload is too close to the end to
  // hold even its header, so it is reported at once, and the last unit lies
  // past the end of the method.
  localparam logic [16:0] TOUR_B [4] = '{
    17'h1_0300, 17'h0_0100, 17'h0_0200, 17'h0_00FF
  };

  typedef struct packed {
    logic [dild_pkg::START_W-1:0]  start;
    logic [7:0]                    op;
    logic [dild_pkg::LENGTH_W-1:0] len;
    logic [1:0]                    kind;
    logic                          clamped;
  } insn_rec_t;

  // Tracks the decoder's view of the code stream and holds the instruction
  // beats it must produce, oldest first.
  class insn_scoreboard;
    logic [dild_pkg::UNIT_W-1:0]  window [dild_pkg::QUEUE_DEPTH];
    int                           window_len;
    logic [dild_pkg::START_W-1:0] cur_offset;
    logic [dild_pkg::TOTAL_W-1:0] method_units;
    int                           units_to_skip;
    insn_rec_t                    expected_insns [$];
    int                           errors;
    int                           n_checked;
    int                           n_clamped;
    int                           kind_seen [4];

    function new();
      window_len    = 0;
      cur_offset    = '0;
      method_units  = '0;
      units_to_skip = 0;
      errors        = 0;
      n_checked     = 0;
      n_clamped     = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function void set_total(logic [dild_pkg::TOTAL_W-1:0] v);
      method_units = v;
    endfunction

    function int outstanding();
      return expected_insns.size();
    endfunction

    // Retire the oldest buffered unit.
    function void advance();
      for (int i = 0; i < dild_pkg::QUEUE_DEPTH - 1; i++) window[i] = window[i + 1];
      window_len--;
      cur_offset++;
    endfunction

    function void drop_skipped();
      while (units_to_skip > 0 && window_len > 0) begin
        advance();
        units_to_skip--;
      end
    endfunction

    function void note_unit(logic [dild_pkg::UNIT_W-1:0] u, logic rs);
      logic [dild_pkg::UNIT_W-1:0] front;
      logic [1:0]                  k;
      int                          need;
      longint unsigned             minlen, len, cnt, off64, tot64;
      bit                          clamp;
      insn_rec_t                   rec;
      if (rs) begin
        cur_offset    = '0;
        units_to_skip = 0;
        window_len    = 0;
      end
      if (window_len < dild_pkg::QUEUE_DEPTH) begin
        window[window_len] = u;
        window_len++;
      end
      drop_skipped();
      if (window_len == 0) return;

      front  = window[0];
      k      = dild_pkg::KIND_ORDINARY;
      need   = 1;
      minlen = 1;
      case (front)
        dild_pkg::PACKED_SWITCH_ID: begin
          k = dild_pkg::KIND_PACKED; need = 2; minlen = 4;
        end
        dild_pkg::SPARSE_SWITCH_ID: begin
          k = dild_pkg::KIND_SPARSE; need = 2; minlen = 2;
        end
        dild_pkg::FILL_ARRAY_ID: begin
          k = dild_pkg::KIND_FILL; need = 4; minlen = 4;
        end
        default: ;
      endcase
      off64 = 64'(cur_offset);
      tot64 = 64'(method_units);

      // A payload that cannot even fit its smallest form is reported now.
      if (k != dild_pkg::KIND_ORDINARY && off64 + minlen > tot64) begin
        len = minlen;
      end else if (window_len < need) begin
        return;
      end else begin
        case (k)
          dild_pkg::KIND_PACKED: len = 64'd4 + 64'd2 * 64'(window[1]);
          dild_pkg::KIND_SPARSE: len = 64'd2 + 64'd4 * 64'(window[1]);
          dild_pkg::KIND_FILL: begin
            cnt = {32'd0, window[3], window[2]};
            len = 64'd4 + (64'(window[1]) * cnt + 64'd1) / 64'd2;
          end
          default: len = 64'(dild_pkg::SIZE_TABLE[front[7:0]]);
        endcase
      end

      clamp = (len == 0 || len > dild_pkg::MAX_LENGTH_DEFAULT || off64 + len > tot64);
      if (clamp) len = 1;

      rec.start   = cur_offset;
      rec.op      = front[7:0];
      rec.len     = len[dild_pkg::LENGTH_W-1:0];
      rec.kind    = k;
      rec.clamped = clamp;
      expected_insns.insert(expected_insns.size(), rec);

      advance();
      units_to_skip = int'(len) - 1;
      drop_skipped();
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_insn(insn_rec_t got);
      insn_rec_t want;
      if (expected_insns.size() == 0) begin
        report_mismatch($sformatf("unexpected beat, start_offset %0d opcode 0x%02h",
                                  got.start, got.op));
        return;
      end
      want = expected_insns.pop_front();
      n_checked++;
      if (want.clamped) n_clamped++;
      kind_seen[want.kind]++;
      if (got.start !== want.start)
        report_mismatch($sformatf("start_offset got %0d want %0d", got.start, want.start));
      if (got.op !== want.op)
        report_mismatch($sformatf("opcode got 0x%02h want 0x%02h at offset %0d",
                                  got.op, want.op, want.start));
      if (got.len !== want.len)
        report_mismatch($sformatf("length_units got %0d want %0d at offset %0d",
                                  got.len, want.len, want.start));
      if (got.kind !== want.kind)
        report_mismatch($sformatf("kind got %0d want %0d at offset %0d",
                                  got.kind, want.kind, want.start));
      if (got.clamped !== want.clamped)
        report_mismatch($sformatf("clamped got %b want %b at offset %0d",
                                  got.clamped, want.clamped, want.start));
    endtask
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [dild_pkg::TOTAL_W-1:0]  cfg_wdata = '0;
  logic                          unit_valid = 1'b0;
  logic                          unit_stall;
  logic [dild_pkg::UNIT_W-1:0]   code_unit = '0;
  logic                          restart = 1'b0;
  logic                          insn_valid;
  logic                          insn_stall = 1'b0;
  logic [dild_pkg::START_W-1:0]  start_offset;
  logic [7:0]                    opcode;
  logic [dild_pkg::LENGTH_W-1:0] length_units;
  logic [1:0]                    kind;
  logic                          clamped;

  insn_scoreboard sb = new();

  // Shared stimulus controls: quiet turns off random gaps on both sides,
  // long_hold asks the receiver to hold off until it counts down to zero.
  bit quiet = 1'b0;
  int long_hold = 0;
  int units_sent = 0;
  int settings_written = 0;

  dalvik_insn_length_decoder u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .unit_valid   (unit_valid),
    .unit_stall   (unit_stall),
    .code_unit    (code_unit),
    .restart      (restart),
    .insn_valid   (insn_valid),
    .insn_stall   (insn_stall),
    .start_offset (start_offset),
    .opcode       (opcode),
    .length_units (length_units),
    .kind         (kind),
    .clamped      (clamped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard timeout: anything still running here has hung.
  initial begin
    #(RUN_LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Watch both channels at every edge. Values read here are the ones held
  // before the edge, so sampling does not race the decoder's own updates.
  // Note the code beat first: a result never shows on the edge that takes
  // the unit that causes it.
  always @(posedge clk) begin : beat_monitor
    insn_rec_t got;
    if (!rst) begin
      if (unit_valid && !unit_stall) sb.note_unit(code_unit, restart);
      if (insn_valid && !insn_stall) begin
        got.start   = start_offset;
        got.op      = opcode;
        got.len     = length_units;
        got.kind    = kind;
        got.clamped = clamped;
        sb.check_insn(got);
      end
    end
  end

  // Receiver side: drive insn_stall at most once per edge. A long hold is
  // counted down here, cycle by cycle, while the sender keeps offering units.
  initial begin : insn_receiver
    int run_left;
    bit hold_now;
    run_left = 0;
    forever begin
      @(posedge clk);
      if (long_hold > 0) begin
        insn_stall <= 1'b1;
        long_hold--;
      end else if (quiet) begin
        insn_stall <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        hold_now = ($urandom_range(0, 3) == 0);
        insn_stall <= hold_now;
        run_left = hold_now ? idle_len() : $urandom_range(0, 6);
      end
    end
  end

  // Offer one code beat, after an optional gap, and hold it until taken.
  // Each call touches unit_valid at most once per edge: either drop it for
  // a gap or keep it high for the next beat.
  task automatic send_unit(logic [dild_pkg::UNIT_W-1:0] u, logic rs);
    int gap;
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      unit_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    unit_valid <= 1'b1;
    code_unit  <= u;
    restart    <= rs;
    @(posedge clk);
    while (unit_stall) @(posedge clk);
    units_sent++;
  endtask

  // Write the method size while the decoder is idle.
  task automatic write_total(logic [dild_pkg::TOTAL_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_total(v);
    settings_written++;
  endtask

  // Drop valid, wait for every predicted beat, then let a pending payload
  // header settle before anything else changes.
  task automatic finish_phase();
    unit_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Build the beats of one instruction: mostly well-formed with random
  // content, some payloads with wild headers (header only, no body), and
  // some pure noise that may carry stray restarts.
  function automatic void build_insn(ref logic [16:0] beats [$]);
    int          pick, n;
    logic [7:0]  op;
    logic [15:0] w;
    logic [31:0] c;
    bit          wild;
    beats.delete();
    pick = $urandom_range(0, 99);
    wild = ($urandom_range(0, 5) == 0);
    if (pick < 70) begin
      op = 8'($urandom);
      beats.insert(beats.size(), {1'b0, 8'($urandom), op});
      repeat (int'(dild_pkg::SIZE_TABLE[op]) - 1)
        beats.insert(beats.size(), {1'b0, 16'($urandom)});
    end else if (pick < 78) begin
      n = wild ? $urandom_range(249, 65535) : $urandom_range(0, 6);
      beats.insert(beats.size(), {1'b0, dild_pkg::PACKED_SWITCH_ID});
      beats.insert(beats.size(), {1'b0, 16'(n)});
      if (!wild) repeat (2 + 2 * n) beats.insert(beats.size(), {1'b0, 16'($urandom)});
    end else if (pick < 86) begin
      n = wild ? $urandom_range(125, 65535) : $urandom_range(0, 4);
      beats.insert(beats.size(), {1'b0, dild_pkg::SPARSE_SWITCH_ID});
      beats.insert(beats.size(), {1'b0, 16'(n)});
      if (!wild) repeat (4 * n) beats.insert(beats.size(), {1'b0, 16'($urandom)});
    end else if (pick < 94) begin
      w = wild ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(0, 4));
      c = wild ? 32'($urandom) : 32'($urandom_range(0, 10));
      beats.insert(beats.size(), {1'b0, dild_pkg::FILL_ARRAY_ID});
      beats.insert(beats.size(), {1'b0, w});
      beats.insert(beats.size(), {1'b0, c[15:0]});
      beats.insert(beats.size(), {1'b0, c[31:16]});
      if (!wild)
        repeat ((int'(w) * int'(c) + 1) / 2) beats.insert(beats.size(), {1'b0, 16'($urandom)});
    end else begin
      repeat ($urandom_range(1, 3))
        beats.insert(beats.size(), {1'($urandom_range(0, 3) == 0), 16'($urandom)});
    end
  endfunction

  // One method: restart on its first unit, then instructions until the
  // chosen size is reached.
  task automatic send_method();
    logic [16:0] beats [$];
    int          target, done;
    bit          first;
    target = $urandom_range(4, 40);
    done   = 0;
    first  = 1'b1;
    while (done < target) begin
      build_insn(beats);
      foreach (beats[i]) send_unit(beats[i][15:0], beats[i][16] | (first && i == 0));
      first = 1'b0;
      done += beats.size();
    end
  endtask

  initial begin : stimulus
    logic [dild_pkg::TOTAL_W-1:0] total;
    int                           phase_start;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed tour first.
    write_total(32'd24);
    foreach (TOUR_A[i]) send_unit(TOUR_A[i][15:0], TOUR_A[i][16]);
    finish_phase();
    write_total(32'd2);
    foreach (TOUR_B[i]) send_unit(TOUR_B[i][15:0], TOUR_B[i][16]);
    finish_phase();

    // Random methods under several sizes, both extremes included. The
    // first phase starts with a long receiver hold against a sender with
    // no gaps, so the decoder backs up and stalls its input; a later phase
    // runs with no idling at all.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       total = 32'hFFFF_FFFF;
        1:       total = 32'd0;
        2:       total = 32'd1;
        3:       total = 32'($urandom_range(16, 160));
        4:       total = 32'($urandom);
        default: total = 32'd500;
      endcase
      write_total(total);
      quiet = (p == 0 || p == 4);
      if (p == 0) long_hold = 80;
      phase_start = units_sent;
      while (units_sent - phase_start < PHASE_UNITS) send_method();
      finish_phase();
      quiet = 1'b0;
    end

    // finish_phase only returns once no beat is still owed, so a missing
    // beat ends the run through the timeout instead.
    $display("Run covered %0d code units under %0d method sizes; %0d beats checked, %0d clamped.",
             units_sent, settings_written, sb.n_checked, sb.n_clamped);
    $display("Beats by kind: ordinary %0d, packed switch %0d, sparse switch %0d, fill array %0d.",
             sb.kind_seen[dild_pkg::KIND_ORDINARY], sb.kind_seen[dild_pkg::KIND_PACKED],
             sb.kind_seen[dild_pkg::KIND_SPARSE], sb.kind_seen[dild_pkg::KIND_FILL]);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
